// File: rtl/mfb_pkg.sv
`timescale 1ns / 1ps

package mfb_pkg;

    localparam int ROWS             = 96;
    localparam int BYTES_PER_ROW    = 12;
    localparam int MAX_GLYPH_HEIGHT = 32;

    localparam int FB_DEPTH     = ROWS * BYTES_PER_ROW;
    localparam int ADDR_W       = $clog2(FB_DEPTH);
    localparam int ROW_W        = 7;
    localparam int COL_W        = 4;
    localparam int BIT_W        = 3;
    localparam int GLYPH_LIMIT  = (MAX_GLYPH_HEIGHT < 32) ? MAX_GLYPH_HEIGHT : 32;
    localparam int CNT_MAX      = (GLYPH_LIMIT > BYTES_PER_ROW) ? GLYPH_LIMIT : BYTES_PER_ROW;
    localparam int CNT_W        = $clog2(CNT_MAX + 1);
    localparam int RCNT_W       = $clog2((1 << ROW_W) + GLYPH_LIMIT + 1);

    typedef enum logic [2:0] {
        OP_SET_CURSOR = 3'd0,
        OP_DRAW       = 3'd1,
        OP_WRITE      = 3'd2,
        OP_FILL       = 3'd3,
        OP_READ       = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ROP_OR       = 2'd0,
        ROP_COPY     = 2'd1,
        ROP_INV_COPY = 2'd2,
        ROP_INVERT   = 2'd3
    } rop_t;

    // byte address of (row, column) in the buffer, row major
    function automatic logic [ADDR_W-1:0] fb_index(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
        int idx;
        idx = int'(r) * BYTES_PER_ROW + int'(c);
        return idx[ADDR_W-1:0];
    endfunction

endpackage

// File: rtl/mfb_rop.sv
`timescale 1ns / 1ps

module mfb_rop
    import mfb_pkg::*;
(
    input  logic [7:0] dst,
    input  logic [7:0] mask,
    input  logic       src,
    input  logic [1:0] rop,
    output logic [7:0] result
);

    always_comb
    begin
        case (rop)
            ROP_OR:       result = src ? (dst | mask) : dst;
            ROP_COPY:     result = src ? (dst | mask) : (dst & ~mask);
            ROP_INV_COPY: result = src ? (dst & ~mask) : (dst | mask);
            default:      result = dst ^ mask;
        endcase
    end

endmodule

// File: rtl/mono_frame_buffer_glyph_blitter_unit.sv
`timescale 1ns / 1ps
// set cursor, write byte and unused ops go straight to S_DONE, read byte passes through S_READ,
// fill row writes the row's BYTES_PER_ROW bytes in S_FILL, glyph column rows run through S_DRAW
// throughput: one command at a time, the next start is taken the cycle after done
// the single buffer port pair sets the rate: one read and one write per cycle, rows pipelined
// reset clears the cursor, then a clearing pass zeroes all 1152 buffer bytes with busy high
// the result is valid from the done cycle until the next command is accepted and the receiver cannot stall it
module mono_frame_buffer_glyph_blitter_unit
    import mfb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    input  logic [2:0]           op,
    input  logic [ROW_W-1:0]     row,
    input  logic [COL_W-1:0]     byte_col,
    input  logic [BIT_W-1:0]     bit_pos,
    input  logic [31:0]          column_bits,
    input  logic [5:0]           glyph_height,
    input  logic [1:0]           raster_op,
    input  logic [7:0]           data_byte,
    output logic [7:0]           read_data,
    output logic [COL_W-1:0]     cursor_col,
    output logic [BIT_W-1:0]     cursor_bit,
    output logic                 line_full
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_FILL  = 6'b001000,
        S_DRAW  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [BIT_W-1:0]    cur_bit_reg, cur_bit_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RCNT_W-1:0]   rcnt_reg, rcnt_next;
    logic [31:0]         bits_reg, bits_next;
    logic [1:0]          rop_reg, rop_next;
    logic [7:0]          data_reg, data_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [7:0]          read_data_reg, read_data_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                pend_src_reg, pend_src_next;

    logic [7:0]          mem [FB_DEPTH];
    logic [7:0]          rdata_reg;
    logic                we, re;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [7:0]          wdata;

    logic                accept;
    logic                in_ok;
    logic [ADDR_W-1:0]   in_addr;
    logic [6:0]          height_lim;
    logic [7:0]          mask;
    logic [7:0]          rop_byte;
    logic                issue;

    assign accept    = start && (state_reg == S_IDLE);
    assign in_ok     = (int'(row) < ROWS) && (int'(byte_col) < BYTES_PER_ROW);
    assign in_addr   = fb_index(row, byte_col);
    assign height_lim = (int'(glyph_height) > GLYPH_LIMIT) ? 7'(GLYPH_LIMIT)
                                                           : {1'b0, glyph_height};
    assign mask      = 8'(1) << cur_bit_reg;
    assign issue     = (cnt_reg != '0) && (int'(rcnt_reg) < ROWS);

    mfb_rop u_rop (
        .dst    (rdata_reg),
        .mask   (mask),
        .src    (pend_src_reg),
        .rop    (rop_reg),
        .result (rop_byte)
    );

    always_comb
    begin
        state_next     = state_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        cur_bit_next   = cur_bit_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        rcnt_next      = rcnt_reg;
        bits_next      = bits_reg;
        rop_next       = rop_reg;
        data_next      = data_reg;
        rd_ok_next     = rd_ok_reg;
        read_data_next = read_data_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        pend_src_next  = pend_src_reg;
        we             = 1'b0;
        waddr          = addr_reg;
        wdata          = data_reg;
        re             = 1'b0;
        raddr          = addr_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                we        = 1'b1;
                wdata     = '0;
                addr_next = addr_reg + 1'b1;
                if (int'(addr_reg) == FB_DEPTH - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    read_data_next = '0;
                    state_next     = S_DONE;
                    case (op)
                        OP_SET_CURSOR:
                        begin
                            cur_row_next = row;
                            cur_col_next = (int'(byte_col) >= BYTES_PER_ROW)
                                           ? COL_W'(BYTES_PER_ROW) : byte_col;
                            cur_bit_next = bit_pos;
                        end
                        OP_DRAW:
                        begin
                            if (int'(cur_col_reg) < BYTES_PER_ROW)
                            begin
                                addr_next  = fb_index(cur_row_reg, cur_col_reg);
                                rcnt_next  = RCNT_W'(cur_row_reg);
                                cnt_next   = CNT_W'(height_lim);
                                bits_next  = column_bits;
                                rop_next   = raster_op;
                                state_next = S_DRAW;
                            end
                        end
                        OP_WRITE:
                        begin
                            we    = in_ok;
                            waddr = in_addr;
                            wdata = data_byte;
                        end
                        OP_FILL:
                        begin
                            if (int'(row) < ROWS)
                            begin
                                addr_next  = fb_index(row, '0);
                                cnt_next   = CNT_W'(BYTES_PER_ROW);
                                data_next  = data_byte;
                                state_next = S_FILL;
                            end
                        end
                        OP_READ:
                        begin
                            re         = 1'b1;
                            raddr      = in_addr;
                            rd_ok_next = in_ok;
                            state_next = S_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                read_data_next = rd_ok_reg ? rdata_reg : '0;
                state_next     = S_DONE;
            end
            S_FILL:
            begin
                we        = 1'b1;
                addr_next = addr_reg + 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DRAW:
            begin
                // write back the row read last cycle while the next row is read
                we    = pend_reg;
                waddr = pend_addr_reg;
                wdata = rop_byte;
                if (issue)
                begin
                    re             = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = addr_reg;
                    pend_src_next  = bits_reg[0];
                    bits_next      = bits_reg >> 1;
                    addr_next      = addr_reg + ADDR_W'(BYTES_PER_ROW);
                    rcnt_next      = rcnt_reg + 1'b1;
                    cnt_next       = cnt_reg - 1'b1;
                end
                else
                begin
                    if (cur_bit_reg == '1)
                    begin
                        cur_bit_next = '0;
                        cur_col_next = cur_col_reg + 1'b1;
                    end
                    else
                    begin
                        cur_bit_next = cur_bit_reg + 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            cur_bit_reg <= '0;
            addr_reg    <= '0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            cur_bit_reg <= cur_bit_next;
            addr_reg    <= addr_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rcnt_reg      <= rcnt_next;
        bits_reg      <= bits_next;
        rop_reg       <= rop_next;
        data_reg      <= data_next;
        rd_ok_reg     <= rd_ok_next;
        read_data_reg <= read_data_next;
        pend_addr_reg <= pend_addr_next;
        pend_src_reg  <= pend_src_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_DONE);
    assign read_data  = read_data_reg;
    assign cursor_col = cur_col_reg;
    assign cursor_bit = cur_bit_reg;
    assign line_full  = (int'(cur_col_reg) >= BYTES_PER_ROW);

endmodule
